[src/pga_pkg.sv]
// types and widths shared by the pairwise gravity acceleration pipeline
// no dependencies
`default_nettype none
package pga_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned MASS_W     = 32;
  localparam int unsigned RES_W      = 48;
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned NUM_W      = 64;
  localparam int unsigned ROOT_W     = 49;
  localparam int unsigned SQREM_W    = ROOT_W + 2;
  localparam int unsigned RAD_W      = SQ_W + 32;
  localparam int unsigned SLO_W      = 33;
  localparam int unsigned RLO_W      = 25;
  localparam int unsigned DEN_W      = 115;
  localparam int unsigned DREM_W     = DEN_W + 1;
  localparam int unsigned Q_W        = RES_W;
  localparam int unsigned NUM_SHIFT  = 8;

  typedef struct packed {
    logic signed [POS_W-1:0] self_x;
    logic signed [POS_W-1:0] self_y;
    logic signed [POS_W-1:0] self_z;
    logic signed [POS_W-1:0] source_x;
    logic signed [POS_W-1:0] source_y;
    logic signed [POS_W-1:0] source_z;
    logic [MASS_W-1:0]       source_mass;
  } pga_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] accel_x;
    logic signed [RES_W-1:0] accel_y;
    logic signed [RES_W-1:0] accel_z;
    logic                    coincident;
    logic                    saturated;
  } pga_out_t;

  // data carried along the square root stages
  typedef struct packed {
    logic                     coinc;
    logic [SQ_W-1:0]          s;
    logic [2:0][NUM_W-1:0]    num;
    logic [2:0]               neg;
  } pga_sqp_t;

  // data carried along the divider stages
  typedef struct packed {
    logic                     coinc;
    logic [2:0]               neg;
    logic [2:0]               ovf;
    logic [DEN_W-1:0]         den;
  } pga_dvp_t;

endpackage
`default_nettype wire

[src/pairwise_gravity_acceleration.sv]
// pairwise gravity acceleration, fully pipelined top level
// depends on pga_pkg
`default_nettype none
// One body pair per request, a new request every cycle (busy is always low).
// Each result appears with done_o after its request has gone through these
// stages: one stage for differences, one for products, one for the sum of
// squares, 49 square root stages (one root bit each), two stages for the
// denominator product, one overflow check, 48 divider stages (one quotient
// bit each, three axes side by side) and one output register. The receiver
// cannot hold results off, so the pipeline never stalls.
module pairwise_gravity_acceleration import pga_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire pga_in_t  in_i,
  output logic          done_o,
  output pga_out_t      res_o
);

  localparam int unsigned NSQ = ROOT_W;
  localparam int unsigned NDV = Q_W;

  assign busy = 1'b0;

  // stage 1: differences
  logic                  v1_q;
  logic [2:0][DIFF_W-1:0] mag1_q;
  logic [2:0]            neg1_q;
  logic [MASS_W-1:0]     mass1_q;
  logic signed [DIFF_W-1:0] dx, dy, dz;

  assign dx = DIFF_W'(in_i.source_x) - DIFF_W'(in_i.self_x);
  assign dy = DIFF_W'(in_i.source_y) - DIFF_W'(in_i.self_y);
  assign dz = DIFF_W'(in_i.source_z) - DIFF_W'(in_i.self_z);

  always_ff @(posedge clk_i) begin
    mag1_q[0] <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    mag1_q[1] <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    mag1_q[2] <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    neg1_q    <= {dz[DIFF_W-1], dy[DIFF_W-1], dx[DIFF_W-1]};
    mass1_q   <= in_i.source_mass;
  end

  // stage 2: squares and mass products
  logic                  v2_q;
  logic [2:0][SQ_W-1:0]  sq2_q;
  logic [2:0][NUM_W-1:0] num2_q;
  logic [2:0]            neg2_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq2_q[k]  <= SQ_W'(mag1_q[k]) * SQ_W'(mag1_q[k]);
      num2_q[k] <= NUM_W'(NUM_W'(mass1_q) * NUM_W'(mag1_q[k]));
    end
    neg2_q <= neg1_q;
  end

  // square root stages, index 0 is the sum of squares
  logic                   sv_q   [NSQ+1];
  pga_sqp_t               sp_q   [NSQ+1];
  logic [SQREM_W-1:0]     srem_q [NSQ+1];
  logic [ROOT_W-1:0]      root_q [NSQ+1];
  logic [SQ_W-1:0]        ssum;

  assign ssum = sq2_q[0] + sq2_q[1] + sq2_q[2];

  always_ff @(posedge clk_i) begin
    sp_q[0].s     <= ssum;
    sp_q[0].coinc <= (ssum == '0);
    sp_q[0].num   <= num2_q;
    sp_q[0].neg   <= neg2_q;
    srem_q[0]     <= '0;
    root_q[0]     <= '0;
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [RAD_W-1:0]     rad;
    logic [SQREM_W+1:0]   cur;
    logic [SQREM_W+1:0]   trial;
    logic                 take;

    assign rad   = {sp_q[k].s, 32'b0};
    assign cur   = {srem_q[k], rad[RAD_W-1-2*k], rad[RAD_W-2-2*k]};
    assign trial = (SQREM_W+2)'({root_q[k], 2'b01});
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i) begin
      sp_q[k+1]   <= sp_q[k];
      srem_q[k+1] <= take ? SQREM_W'(cur - trial) : SQREM_W'(cur);
      root_q[k+1] <= {root_q[k][ROOT_W-2:0], take};
    end
  end

  // denominator: partial products then sum
  logic                      vp_q;
  logic [SLO_W+RLO_W-1:0]    pp00_q, pp01_q, pp10_q, pp11_q;
  pga_sqp_t                  pp_q;
  logic [SLO_W-1:0]          s_lo, s_hi;
  logic [RLO_W-1:0]          r_lo, r_hi;

  assign s_lo = sp_q[NSQ].s[SLO_W-1:0];
  assign s_hi = sp_q[NSQ].s[SQ_W-1:SLO_W];
  assign r_lo = root_q[NSQ][RLO_W-1:0];
  assign r_hi = RLO_W'(root_q[NSQ][ROOT_W-1:RLO_W]);

  always_ff @(posedge clk_i) begin
    pp00_q <= (SLO_W+RLO_W)'(s_lo) * (SLO_W+RLO_W)'(r_lo);
    pp01_q <= (SLO_W+RLO_W)'(s_lo) * (SLO_W+RLO_W)'(r_hi);
    pp10_q <= (SLO_W+RLO_W)'(s_hi) * (SLO_W+RLO_W)'(r_lo);
    pp11_q <= (SLO_W+RLO_W)'(s_hi) * (SLO_W+RLO_W)'(r_hi);
    pp_q   <= sp_q[NSQ];
  end

  logic                  vd_q;
  logic [DEN_W-1:0]      den_q;
  pga_sqp_t              dd_q;

  always_ff @(posedge clk_i) begin
    den_q <= DEN_W'(pp00_q)
           + (DEN_W'(pp01_q) << RLO_W)
           + (DEN_W'(pp10_q) << SLO_W)
           + (DEN_W'(pp11_q) << (SLO_W + RLO_W));
    dd_q  <= pp_q;
  end

  // divider stages, index 0 holds the overflow check and start remainder
  logic                   dv_q   [NDV+1];
  pga_dvp_t               dp_q   [NDV+1];
  logic [2:0][DREM_W-1:0] drem_q [NDV+1];
  logic [2:0][Q_W-1:0]    quo_q  [NDV+1];

  always_ff @(posedge clk_i) begin
    dp_q[0].coinc <= dd_q.coinc;
    dp_q[0].neg   <= dd_q.neg;
    dp_q[0].den   <= den_q;
    for (int k = 0; k < 3; k++) begin
      // quotient reaches 2^48 when num * 2^8 >= den
      dp_q[0].ovf[k] <= ({dd_q.num[k], NUM_SHIFT'(0)} >= DREM_W'(den_q));
      drem_q[0][k]   <= DREM_W'({dd_q.num[k], NUM_SHIFT'(0)});
      quo_q[0][k]    <= '0;
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_div
    logic [2:0][DREM_W-1:0] sh;
    logic [2:0]             take;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        sh[k]   = {drem_q[j][k][DREM_W-2:0], 1'b0};
        take[k] = (sh[k] >= DREM_W'(dp_q[j].den));
      end
    end

    always_ff @(posedge clk_i) begin
      dp_q[j+1] <= dp_q[j];
      for (int k = 0; k < 3; k++) begin
        drem_q[j+1][k] <= take[k] ? DREM_W'(sh[k] - DREM_W'(dp_q[j].den)) : sh[k];
        quo_q[j+1][k]  <= {quo_q[j][k][Q_W-2:0], take[k]};
      end
    end
  end

  // clamp, sign and output register
  logic [2:0][RES_W-1:0] acc;
  logic [2:0]            sat;

  always_comb begin
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] m;
    for (int k = 0; k < 3; k++) begin
      lim    = dp_q[NDV].neg[k] ? Q_W'(1) << (RES_W - 1)
                                : (Q_W'(1) << (RES_W - 1)) - Q_W'(1);
      sat[k] = dp_q[NDV].ovf[k] || (quo_q[NDV][k] > lim);
      m      = sat[k] ? lim : quo_q[NDV][k];
      acc[k] = dp_q[NDV].neg[k] ? RES_W'(-m) : RES_W'(m);
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.accel_x    <= dp_q[NDV].coinc ? '0 : acc[0];
    res_o.accel_y    <= dp_q[NDV].coinc ? '0 : acc[1];
    res_o.accel_z    <= dp_q[NDV].coinc ? '0 : acc[2];
    res_o.coincident <= dp_q[NDV].coinc;
    res_o.saturated  <= !dp_q[NDV].coinc && (sat != '0);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vp_q   <= 1'b0;
      vd_q   <= 1'b0;
      done_o <= 1'b0;
      for (int k = 0; k <= NSQ; k++) sv_q[k] <= 1'b0;
      for (int j = 0; j <= NDV; j++) dv_q[j] <= 1'b0;
    end else begin
      v1_q    <= start;
      v2_q    <= v1_q;
      sv_q[0] <= v2_q;
      for (int k = 0; k < NSQ; k++) sv_q[k+1] <= sv_q[k];
      vp_q    <= sv_q[NSQ];
      vd_q    <= vp_q;
      dv_q[0] <= vd_q;
      for (int j = 0; j < NDV; j++) dv_q[j+1] <= dv_q[j];
      done_o  <= dv_q[NDV];
    end
  end

endmodule
`default_nettype wire
